// ===== src/drhz_pkg.sv =====
`timescale 1ns / 1ps

package drhz_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int CFG_IDX_BITS = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_LIMIT       = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEAVE_CLOSE_LIMIT = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEAVE_FAR_LIMIT   = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAR_LIMIT         = 4'd3;

    localparam logic [SAMPLE_BITS-1:0] RST_CLOSE_LIMIT       = 10'd40;
    localparam logic [SAMPLE_BITS-1:0] RST_LEAVE_CLOSE_LIMIT = 10'd60;
    localparam logic [SAMPLE_BITS-1:0] RST_LEAVE_FAR_LIMIT   = 10'd500;
    localparam logic [SAMPLE_BITS-1:0] RST_FAR_LIMIT         = 10'd550;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        ZONE_IN    = 2'd0,
        ZONE_CLOSE = 2'd1,
        ZONE_FAR   = 2'd2
    } zone_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
    } sample_t;

    typedef struct packed {
        logic [1:0] zone_event;
        logic       side;
        logic       last_event;
    } evt_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] close_limit;
        logic [SAMPLE_BITS-1:0] leave_close_limit;
        logic [SAMPLE_BITS-1:0] leave_far_limit;
        logic [SAMPLE_BITS-1:0] far_limit;
    } limits_t;

    typedef struct packed {
        logic  chg;
        zone_t zone;
    } lane_res_t;

endpackage

// ===== src/drhz_lane.sv =====
`timescale 1ns / 1ps

module drhz_lane
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [drhz_pkg::SAMPLE_BITS-1:0] sample,
    input  drhz_pkg::limits_t              limits,
    output drhz_pkg::lane_res_t            res
);

    drhz_pkg::zone_t zone_reg;
    drhz_pkg::zone_t zone_next;

    always_comb
    begin
        zone_next = zone_reg;
        case (zone_reg)
            drhz_pkg::ZONE_IN:
            begin
                if (sample < limits.close_limit)
                begin
                    zone_next = drhz_pkg::ZONE_CLOSE;
                end
                else if (sample > limits.far_limit)
                begin
                    zone_next = drhz_pkg::ZONE_FAR;
                end
            end
            drhz_pkg::ZONE_CLOSE:
            begin
                if (sample > limits.leave_close_limit)
                begin
                    zone_next = drhz_pkg::ZONE_IN;
                end
            end
            drhz_pkg::ZONE_FAR:
            begin
                if (sample < limits.leave_far_limit)
                begin
                    zone_next = drhz_pkg::ZONE_IN;
                end
            end
            default:
            begin
                zone_next = zone_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= drhz_pkg::ZONE_IN;
        end
        else if (accept)
        begin
            zone_reg <= zone_next;
        end
    end

    assign res.chg  = (zone_next != zone_reg);
    assign res.zone = zone_next;

endmodule

// ===== src/drhz_merge.sv =====
`timescale 1ns / 1ps

module drhz_merge
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                smp_valid,
    input  drhz_pkg::lane_res_t left_res,
    input  drhz_pkg::lane_res_t right_res,
    input  logic                evt_stall,
    output logic                ready,
    output logic                evt_valid,
    output drhz_pkg::evt_t      evt_data
);

    logic           slot0_valid_reg;
    logic           slot0_valid_next;
    logic           slot1_valid_reg;
    logic           slot1_valid_next;
    drhz_pkg::evt_t slot0_reg;
    drhz_pkg::evt_t slot0_next;
    drhz_pkg::evt_t slot1_reg;
    drhz_pkg::evt_t slot1_next;
    drhz_pkg::evt_t left_evt;
    drhz_pkg::evt_t right_evt;
    logic           pop;
    logic           accept;
    logic           both;

    assign pop    = slot0_valid_reg && !evt_stall;
    assign ready  = !slot1_valid_reg && (!slot0_valid_reg || pop);
    assign accept = smp_valid && ready;
    assign both   = left_res.chg && right_res.chg;

    always_comb
    begin
        left_evt.zone_event  = left_res.zone;
        left_evt.side        = drhz_pkg::SIDE_LEFT;
        left_evt.last_event  = !both;
        right_evt.zone_event = right_res.zone;
        right_evt.side       = drhz_pkg::SIDE_RIGHT;
        right_evt.last_event = 1'b1;
    end

    always_comb
    begin
        slot0_valid_next = slot0_valid_reg;
        slot1_valid_next = slot1_valid_reg;
        slot0_next       = slot0_reg;
        slot1_next       = slot1_reg;
        if (accept)
        begin
            slot0_valid_next = left_res.chg || right_res.chg;
            slot1_valid_next = both;
            slot0_next       = left_res.chg ? left_evt : right_evt;
            slot1_next       = right_evt;
        end
        else if (pop)
        begin
            // advance the queued beat
            slot0_valid_next = slot1_valid_reg;
            slot1_valid_next = 1'b0;
            slot0_next       = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_valid_reg <= 1'b0;
            slot1_valid_reg <= 1'b0;
        end
        else
        begin
            slot0_valid_reg <= slot0_valid_next;
            slot1_valid_reg <= slot1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign evt_valid = slot0_valid_reg;
    assign evt_data  = slot0_reg;

endmodule

// ===== src/dual_range_hysteresis_zone_events_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Beat
// smp       in         smp_valid / smp_stall  sample_t: left_sample, right_sample
// evt       out        evt_valid / evt_stall  evt_t: zone_event, side, last_event
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample pair is taken at a clock edge; both side lanes update their zone on that edge.
// Its events show from the next cycle, one beat per unstalled cycle from a two-entry output queue.
// With no or one event a new pair can follow every unstalled cycle; two events hold the next until one leaves.
// Reset puts both zones in range and loads the default limits; cfg_ready is always high.
// A stall on evt holds the queue and raises smp_stall until a slot frees.

module dual_range_hysteresis_zone_events_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             smp_valid,
    output logic                             smp_stall,
    input  drhz_pkg::sample_t                smp_data,
    output logic                             evt_valid,
    input  logic                             evt_stall,
    output drhz_pkg::evt_t                   evt_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [drhz_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [drhz_pkg::SAMPLE_BITS-1:0]  cfg_data
);

    drhz_pkg::limits_t   limits_reg;
    drhz_pkg::limits_t   limits_next;
    drhz_pkg::lane_res_t left_res;
    drhz_pkg::lane_res_t right_res;
    logic                ready;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign smp_stall = !ready;
    assign accept    = smp_valid && ready;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                drhz_pkg::CFG_CLOSE_LIMIT:       limits_next.close_limit       = cfg_data;
                drhz_pkg::CFG_LEAVE_CLOSE_LIMIT: limits_next.leave_close_limit = cfg_data;
                drhz_pkg::CFG_LEAVE_FAR_LIMIT:   limits_next.leave_far_limit   = cfg_data;
                drhz_pkg::CFG_FAR_LIMIT:         limits_next.far_limit         = cfg_data;
                default:                         limits_next                   = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.close_limit       <= drhz_pkg::RST_CLOSE_LIMIT;
            limits_reg.leave_close_limit <= drhz_pkg::RST_LEAVE_CLOSE_LIMIT;
            limits_reg.leave_far_limit   <= drhz_pkg::RST_LEAVE_FAR_LIMIT;
            limits_reg.far_limit         <= drhz_pkg::RST_FAR_LIMIT;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    drhz_lane u_lane_left
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (smp_data.left_sample),
        .limits (limits_reg),
        .res    (left_res)
    );

    drhz_lane u_lane_right
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (smp_data.right_sample),
        .limits (limits_reg),
        .res    (right_res)
    );

    drhz_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .left_res  (left_res),
        .right_res (right_res),
        .evt_stall (evt_stall),
        .ready     (ready),
        .evt_valid (evt_valid),
        .evt_data  (evt_data)
    );

endmodule

// ===== tb/sv/tb_dual_range_hysteresis_zone_events_unit.sv =====
`timescale 1ns / 1ps

module tb_dual_range_hysteresis_zone_events_unit;

    import drhz_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 8;
    localparam int PAIRS_PER_PHASE = 125;
    localparam int IDLE_PERCENT   = 13;
    localparam int MAX_SAMPLE     = (1 << SAMPLE_BITS) - 1;
    localparam int MAX_CFG_INDEX  = (1 << CFG_IDX_BITS) - 1;
    localparam int REPORT_LIMIT   = 10;

    class zone_scoreboard;
        limits_t lim;
        zone_t   left_zone;
        zone_t   right_zone;
        evt_t    pending_events[$];
        int      mismatches;

        function new();
            lim.close_limit       = RST_CLOSE_LIMIT;
            lim.leave_close_limit = RST_LEAVE_CLOSE_LIMIT;
            lim.leave_far_limit   = RST_LEAVE_FAR_LIMIT;
            lim.far_limit         = RST_FAR_LIMIT;
            left_zone  = ZONE_IN;
            right_zone = ZONE_IN;
            mismatches = 0;
        endfunction

        function void write_limit(logic [CFG_IDX_BITS-1:0] idx, logic [SAMPLE_BITS-1:0] val);
            case (idx)
                CFG_CLOSE_LIMIT:       lim.close_limit = val;
                CFG_LEAVE_CLOSE_LIMIT: lim.leave_close_limit = val;
                CFG_LEAVE_FAR_LIMIT:   lim.leave_far_limit = val;
                CFG_FAR_LIMIT:         lim.far_limit = val;
                default: ;
            endcase
        endfunction

        function zone_t step_zone(zone_t z, logic [SAMPLE_BITS-1:0] s);
            case (z)
                ZONE_IN:
                begin
                    if (s < lim.close_limit)
                        return ZONE_CLOSE;
                    if (s > lim.far_limit)
                        return ZONE_FAR;
                    return ZONE_IN;
                end
                ZONE_CLOSE: return (s > lim.leave_close_limit) ? ZONE_IN : ZONE_CLOSE;
                ZONE_FAR:   return (s < lim.leave_far_limit) ? ZONE_IN : ZONE_FAR;
                default:    return z;
            endcase
        endfunction

        function void note_pair(sample_t p);
            zone_t nl;
            zone_t nr;
            bit    left_moved;
            nl = step_zone(left_zone, p.left_sample);
            nr = step_zone(right_zone, p.right_sample);
            left_moved = (nl != left_zone);
            if (left_moved)
            begin
                pending_events.push_back('{zone_event: nl, side: SIDE_LEFT, last_event: 1'b1});
                left_zone = nl;
            end
            if (nr != right_zone)
            begin
                if (left_moved)
                    pending_events[pending_events.size() - 1].last_event = 1'b0;
                pending_events.push_back('{zone_event: nr, side: SIDE_RIGHT, last_event: 1'b1});
                right_zone = nr;
            end
        endfunction

        function void report(string what, evt_t want, evt_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s: expected zone %0d side %0d last %0d, got zone %0d side %0d last %0d",
                         what, want.zone_event, want.side, want.last_event,
                         got.zone_event, got.side, got.last_event);
        endfunction

        function void check_event(evt_t got);
            evt_t want;
            if (pending_events.size() == 0)
            begin
                report("event beat with none pending", '0, got);
                return;
            end
            want = pending_events.pop_front();
            if (got.zone_event !== want.zone_event || got.side !== want.side
                || got.last_event !== want.last_event)
                report("event beat mismatch", want, got);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    smp_valid = 1'b0;
    logic                    smp_stall;
    sample_t                 smp_data = '0;
    logic                    evt_valid;
    logic                    evt_stall = 1'b0;
    evt_t                    evt_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [SAMPLE_BITS-1:0]  cfg_data = '0;

    zone_scoreboard sb;
    bit             calm = 1'b0;
    int             cycles = 0;

    dual_range_hysteresis_zone_events_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
        evt_stall <= rst_n && !calm && ($urandom_range(99, 0) < IDLE_PERCENT);

    // Values seen at the falling edge are those in effect at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_limit(cfg_index, cfg_data);
            if (smp_valid && !smp_stall)
                sb.note_pair(smp_data);
            if (evt_valid && !evt_stall)
                sb.check_event(evt_data);
        end
    end

    task automatic send_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
        logic took;
        smp_valid <= 1'b1;
        smp_data  <= '{left_sample: l, right_sample: r};
        do
        begin
            @(negedge clk);
            took = !smp_stall;
            @(posedge clk);
        end
        while (!took);
        if (!calm && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            smp_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_events();
        smp_valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [SAMPLE_BITS-1:0] c, input logic [SAMPLE_BITS-1:0] lc,
                              input logic [SAMPLE_BITS-1:0] lf, input logic [SAMPLE_BITS-1:0] f);
        logic [CFG_IDX_BITS-1:0] idx [5];
        logic [SAMPLE_BITS-1:0]  val [5];
        logic                    took;
        idx = '{CFG_CLOSE_LIMIT, CFG_LEAVE_CLOSE_LIMIT, CFG_LEAVE_FAR_LIMIT, CFG_FAR_LIMIT,
                CFG_CLOSE_LIMIT};
        val = '{c, lc, lf, f, '0};
        // unmapped index: must leave every limit untouched
        idx[4] = CFG_IDX_BITS'($urandom_range(MAX_CFG_INDEX, CFG_FAR_LIMIT + 1));
        val[4] = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
        for (int i = 4; i >= 0; i--)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
            begin
                @(negedge clk);
                took = cfg_ready;
                @(posedge clk);
            end
            while (!took);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] near;
        case ($urandom_range(5, 0))
            0: near = sb.lim.close_limit;
            1: near = sb.lim.leave_close_limit;
            2: near = sb.lim.leave_far_limit;
            3: near = sb.lim.far_limit;
            default: return SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
        endcase
        return SAMPLE_BITS'(near + $urandom_range(2, 0) - 1);
    endfunction

    initial
    begin
        logic [SAMPLE_BITS-1:0] c;
        logic [SAMPLE_BITS-1:0] lc;
        logic [SAMPLE_BITS-1:0] lf;
        logic [SAMPLE_BITS-1:0] f;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: extremes, equality, both sides moving, single side moving
        send_pair(10'd0, 10'd1023);
        send_pair(10'd60, 10'd500);
        send_pair(10'd61, 10'd499);
        send_pair(10'd40, 10'd550);
        send_pair(10'd39, 10'd551);
        send_pair(10'd1023, 10'd0);
        send_pair(10'd1023, 10'd0);
        send_pair(10'd300, 10'd300);
        send_pair(10'd0, 10'd300);
        send_pair(10'd300, 10'd0);
        send_pair(10'd300, 10'd300);
        drain_events();

        // crossed limits: close wins over far, zones toggle
        set_limits(10'd1023, 10'd0, 10'd1023, 10'd0);
        send_pair(10'd500, 10'd500);
        send_pair(10'd500, 10'd500);
        send_pair(10'd0, 10'd1023);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd0, 10'd0);
        send_pair(10'd1023, 10'd512);
        drain_events();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    c = RST_CLOSE_LIMIT;
                    lc = RST_LEAVE_CLOSE_LIMIT;
                    lf = RST_LEAVE_FAR_LIMIT;
                    f = RST_FAR_LIMIT;
                end
                1:
                begin
                    c = '0;
                    lc = '0;
                    lf = '0;
                    f = '0;
                end
                2:
                begin
                    c = '1;
                    lc = '1;
                    lf = '1;
                    f = '1;
                end
                3:
                begin
                    c = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
                    lc = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
                    lf = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
                    f = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, 0));
                end
                default:
                begin
                    c = SAMPLE_BITS'($urandom_range(300, 0));
                    lc = SAMPLE_BITS'($urandom_range(400, c));
                    lf = SAMPLE_BITS'($urandom_range(900, 400));
                    f = SAMPLE_BITS'($urandom_range(MAX_SAMPLE, lf));
                end
            endcase
            set_limits(c, lc, lf, f);
            calm <= (ph == 4);
            for (int n = 0; n < PAIRS_PER_PHASE; n++)
                send_pair(pick_sample(), pick_sample());
            drain_events();
            calm <= 1'b0;
        end

        if (sb.mismatches == 0 && sb.pending_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
